// File: sv/primitive_index_assembler_top_defines.svh
// Assertion macros shared by the primitive index assembler RTL.
// Depends on nothing; included by the files that carry assertions.
// Simulation builds get the checks, synthesis builds get empty bodies.
`ifndef PRIMITIVE_INDEX_ASSEMBLER_TOP_DEFINES_SVH
`define PRIMITIVE_INDEX_ASSEMBLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every edge outside reset.
`define PIA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge at which rst_n is high both now and at the previous edge.
`define PIA_ASSERT_POST_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n || !$past(rst_n)) prop) \
    else $error(msg);
`else
`define PIA_ASSERT(label, clk, rst_n, prop, msg)
`define PIA_ASSERT_POST_RST(label, clk, rst_n, prop, msg)
`endif

`endif

// File: sv/pia_pkg.sv
// Package of the primitive index assembler: codes, the queue entry type
// and default sizes. Depends on nothing; the interfaces, front, back and top use it.
package pia_pkg;

  localparam int INDEX_WIDTH_DEF = 16;
  localparam int FIFO_DEPTH_DEF  = 4;
  localparam int COUNT_W         = 16;
  localparam int FIELD_W         = 16;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_VERTEX = 2'd1,
    OP_END    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    MODE_TRI       = 3'd0,
    MODE_QUAD      = 3'd1,
    MODE_STRIP     = 3'd2,
    MODE_QUADSTRIP = 3'd3,
    MODE_FAN       = 3'd4,
    MODE_LINELOOP  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TRI  = 2'd0,
    KIND_LINE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One classified item: one or two index tuples as offsets from the
  // primitive's first vertex.
  typedef struct packed {
    kind_t              kind;
    logic               two;
    logic [COUNT_W-1:0] a0;
    logic [COUNT_W-1:0] b0;
    logic [COUNT_W-1:0] c0;
    logic [COUNT_W-1:0] a1;
    logic [COUNT_W-1:0] b1;
    logic [COUNT_W-1:0] c1;
  } job_t;

endpackage

// File: sv/pia_if.sv
// Valid/ready channel interfaces for the primitive index assembler.
// Depends on pia_pkg for the field widths.
interface pia_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] prim_mode;
  logic [pia_pkg::FIELD_W-1:0] base_index;

  modport source (output valid, output op, output prim_mode, output base_index,
                  input ready);
  modport sink   (input valid, input op, input prim_mode, input base_index,
                  output ready);
endinterface

interface pia_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [pia_pkg::FIELD_W-1:0] idx_a;
  logic [pia_pkg::FIELD_W-1:0] idx_b;
  logic [pia_pkg::FIELD_W-1:0] idx_c;
  logic       last;

  modport source (output valid, output kind, output idx_a, output idx_b,
                  output idx_c, output last, input ready);
  modport sink   (input valid, input kind, input idx_a, input idx_b,
                  input idx_c, input last, output ready);
endinterface

// File: sv/pia_fifo.sv
// Short register queue between the front and back of the assembler.
// Depends on the assertion macros header; generic in width and depth.
`include "primitive_index_assembler_top_defines.svh"

module pia_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `PIA_ASSERT_POST_RST(a_fifo_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "queue count exceeds depth")

endmodule

// File: sv/pia_front.sv
// Front of the assembler: accepts items, tracks the open primitive and
// classifies each item into a queue entry. Depends on pia_pkg and pia_if.
`include "primitive_index_assembler_top_defines.svh"

module pia_front #(
  parameter int INDEX_WIDTH = pia_pkg::INDEX_WIDTH_DEF,
  localparam int LW = (INDEX_WIDTH < pia_pkg::FIELD_W) ? INDEX_WIDTH : pia_pkg::FIELD_W
) (
  input  logic            clk,
  input  logic            rst_n,
  pia_in_if.sink          in_ch,
  output logic            push,
  output pia_pkg::job_t   job,
  output logic [LW-1:0]   first,
  input  logic            full
);

  localparam int CW = pia_pkg::COUNT_W;

  logic          active_r, active_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [LW-1:0] first_r, first_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    mod3_r, mod3_nxt;
  logic          accept;
  logic          emit;
  logic [CW-1:0] n;
  logic [1:0]    n_mod3;
  logic [CW-1:0] i;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && emit;
  assign first       = first_r;

  // Count after this vertex and its residue modulo three; the residue
  // restarts whenever the count wraps to zero.
  assign n      = count_r + 1'b1;
  assign n_mod3 = (n == '0 || mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
  assign i      = n - CW'(3);

  always_comb begin
    job       = '0;
    job.kind  = pia_pkg::KIND_TRI;
    emit      = 1'b0;
    if (in_ch.op == pia_pkg::OP_VERTEX && active_r) begin
      case (mode_r)
        pia_pkg::MODE_TRI: begin
          emit   = (n >= CW'(3)) && (n_mod3 == 2'd0);
          job.a0 = n - CW'(3);
          job.b0 = n - CW'(2);
          job.c0 = n - CW'(1);
        end
        pia_pkg::MODE_QUAD: begin
          emit    = (n >= CW'(4)) && (n[1:0] == 2'b00);
          job.two = 1'b1;
          job.a0  = n - CW'(4);
          job.b0  = n - CW'(3);
          job.c0  = n - CW'(2);
          job.a1  = n - CW'(4);
          job.b1  = n - CW'(2);
          job.c1  = n - CW'(1);
        end
        pia_pkg::MODE_STRIP: begin
          // Odd triangles swap their first two vertices to keep the winding.
          emit   = (n >= CW'(3));
          job.a0 = i[0] ? i + 1'b1 : i;
          job.b0 = i[0] ? i : i + 1'b1;
          job.c0 = n - CW'(1);
        end
        pia_pkg::MODE_QUADSTRIP: begin
          emit    = (n >= CW'(4)) && !n[0];
          job.two = 1'b1;
          job.a0  = n - CW'(4);
          job.b0  = n - CW'(3);
          job.c0  = n - CW'(1);
          job.a1  = n - CW'(4);
          job.b1  = n - CW'(1);
          job.c1  = n - CW'(2);
        end
        pia_pkg::MODE_FAN: begin
          emit   = (n >= CW'(3));
          job.a0 = '0;
          job.b0 = n - CW'(2);
          job.c0 = n - CW'(1);
        end
        pia_pkg::MODE_LINELOOP: begin
          emit     = (n >= CW'(2));
          job.kind = pia_pkg::KIND_LINE;
          job.a0   = n - CW'(2);
          job.b0   = n - CW'(1);
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (in_ch.op == pia_pkg::OP_END && active_r) begin
      if (mode_r == pia_pkg::MODE_LINELOOP) begin
        // Closing line from the last vertex back to the first.
        emit     = (count_r != '0);
        job.kind = pia_pkg::KIND_LINE;
        job.a0   = count_r - 1'b1;
        job.b0   = '0;
      end else if (mode_r > pia_pkg::MODE_LINELOOP) begin
        emit     = 1'b1;
        job.kind = pia_pkg::KIND_ERR;
      end
    end
  end

  always_comb begin
    active_nxt = active_r;
    mode_nxt   = mode_r;
    first_nxt  = first_r;
    count_nxt  = count_r;
    mod3_nxt   = mod3_r;
    if (accept) begin
      if (in_ch.op == pia_pkg::OP_BEGIN) begin
        active_nxt = 1'b1;
        mode_nxt   = in_ch.prim_mode;
        first_nxt  = in_ch.base_index[LW-1:0];
        count_nxt  = '0;
        mod3_nxt   = 2'd0;
      end else if (in_ch.op == pia_pkg::OP_VERTEX && active_r) begin
        count_nxt = n;
        mod3_nxt  = n_mod3;
      end else if (in_ch.op == pia_pkg::OP_END) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      mode_r   <= '0;
      first_r  <= '0;
      count_r  <= '0;
      mod3_r   <= '0;
    end else begin
      active_r <= active_nxt;
      mode_r   <= mode_nxt;
      first_r  <= first_nxt;
      count_r  <= count_nxt;
      mod3_r   <= mod3_nxt;
    end
  end

  `PIA_ASSERT(a_end_closes, clk, rst_n, accept && in_ch.op == pia_pkg::OP_END |=> !active_r, "primitive still open after end")

endmodule

// File: sv/pia_back.sv
// Back of the assembler: turns queue entries into index beats, one beat a
// ready cycle, through an output register. Depends on pia_pkg and pia_if.
`include "primitive_index_assembler_top_defines.svh"

module pia_back #(
  parameter int INDEX_WIDTH = pia_pkg::INDEX_WIDTH_DEF,
  localparam int LW = (INDEX_WIDTH < pia_pkg::FIELD_W) ? INDEX_WIDTH : pia_pkg::FIELD_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  pia_pkg::job_t   job,
  input  logic [LW-1:0]   first,
  output logic            pop,
  pia_out_if.source       out_ch
);

  localparam int FW = pia_pkg::FIELD_W;

  logic          out_valid_r, out_valid_nxt;
  logic          phase_r, phase_nxt;
  logic [1:0]    kind_r;
  logic [FW-1:0] idx_a_r, idx_b_r, idx_c_r;
  logic          last_r;
  logic          load, take, last_beat;
  logic [LW-1:0] sum_a, sum_b, sum_c;
  logic [pia_pkg::COUNT_W-1:0] off_a, off_b, off_c;

  assign load      = !out_valid_r || out_ch.ready;
  assign take      = load && !empty;
  assign last_beat = !job.two || phase_r;
  assign pop       = take && last_beat;

  assign off_a = phase_r ? job.a1 : job.a0;
  assign off_b = phase_r ? job.b1 : job.b0;
  assign off_c = phase_r ? job.c1 : job.c0;

  // Index sums wrap at the index width.
  assign sum_a = first + off_a[LW-1:0];
  assign sum_b = first + off_b[LW-1:0];
  assign sum_c = first + off_c[LW-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      phase_nxt     = job.two && !phase_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r  <= job.kind;
      last_r  <= last_beat;
      idx_a_r <= (job.kind == pia_pkg::KIND_ERR) ? '0 : FW'(sum_a);
      idx_b_r <= (job.kind == pia_pkg::KIND_ERR) ? '0 : FW'(sum_b);
      idx_c_r <= (job.kind == pia_pkg::KIND_TRI) ? FW'(sum_c) : '0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = kind_r;
  assign out_ch.idx_a = idx_a_r;
  assign out_ch.idx_b = idx_b_r;
  assign out_ch.idx_c = idx_c_r;
  assign out_ch.last  = last_r;

  `PIA_ASSERT(a_phase_has_beat, clk, rst_n, phase_r |-> out_valid_r && !empty, "second beat pending without a shown beat or queue entry")
  `PIA_ASSERT(a_not_last_pending, clk, rst_n, out_valid_r && !out_ch.last |-> phase_r, "beat without last but no second beat pending")

endmodule

// File: sv/primitive_index_assembler_top.sv
// Primitive index assembler: begin, vertex and end beats in, triangle or
// line index beats out. An accepted item passes through the queue and then
// the output register before its first result beat is valid.
// Throughput: one input beat per cycle while the queue has room. An item with two
// tuples fills two output beats, as the back end issues one per cycle while ready.
// Reset (rst_n, synchronous, active low) closes any primitive and empties the queue.
//
// Structure. The front end (pia_front) accepts every input beat while the
// queue has room, keeps the open primitive's mode, first vertex index and
// vertex count, and decides for each beat whether it produces zero, one or
// two index tuples. Beats that produce something are written into a short
// register queue (pia_fifo) as offsets from the first vertex, together with
// the first vertex index in force at that time. The back end (pia_back)
// reads the queue head, adds the offsets to the first index at the index
// width, and presents one tuple per ready cycle through an output register, so
// a stalled consumer never stops the front end until the queue is full.
// The last flag marks the final beat that one input beat causes.
`include "primitive_index_assembler_top_defines.svh"

module primitive_index_assembler_top #(
  parameter int INDEX_WIDTH = pia_pkg::INDEX_WIDTH_DEF,
  parameter int FIFO_DEPTH  = pia_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pia_in_if.sink     in_ch,
  pia_out_if.source  out_ch
);

  // Indices are carried only as wide as both the index width and the
  // output fields allow.
  localparam int LW = (INDEX_WIDTH < pia_pkg::FIELD_W) ? INDEX_WIDTH : pia_pkg::FIELD_W;
  localparam int DW = $bits(pia_pkg::job_t) + LW;

  pia_pkg::job_t push_job, pop_job;
  logic [LW-1:0] push_first, pop_first;
  logic [DW-1:0] push_data, pop_data;
  logic          push, pop, full, empty;

  pia_front #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .push  (push),
    .job   (push_job),
    .first (push_first),
    .full  (full)
  );

  assign push_data = {push_job, push_first};

  pia_fifo #(
    .WIDTH (DW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  assign {pop_job, pop_first} = pop_data;

  pia_back #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .job    (pop_job),
    .first  (pop_first),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // A tuple can only be read out of a queue that holds one.
  `PIA_ASSERT(a_pop_needs_entry, clk, rst_n, pop |-> !empty, "queue read while empty")

endmodule
